/* hdl/wwa_pkg.sv */
`timescale 1ns / 1ps

package wwa_pkg;

	// Window geometry: three frames on each side of the centre
	localparam int MAX_HALF_WINDOW = 3;
	localparam int LANES = 2 * MAX_HALF_WINDOW + 1;
	localparam int CENTER_LANE = MAX_HALF_WINDOW;
	localparam int HW_BITS = 2;

	// Default datapath sizes
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int WEIGHT_BITS_DEF = 16;

	// Register map (index = byte address / 4)
	localparam int ADDR_BITS = 5;
	localparam int REG_IDX_BITS = ADDR_BITS - 2;
	localparam logic [REG_IDX_BITS-1:0] REG_HALF_WINDOW = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_WEIGHT_CENTER = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_WEIGHT_DIST1 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_WEIGHT_DIST2 = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_WEIGHT_DIST3 = 3'd4;

	// Register reset values
	localparam logic [HW_BITS-1:0] HALF_WINDOW_RST = 2'd2;
	localparam int WEIGHT_CENTER_RST = 21845;
	localparam int WEIGHT_DIST1_RST = 14564;
	localparam int WEIGHT_DIST2_RST = 7282;
	localparam int WEIGHT_DIST3_RST = 0;

	// Sideband that travels with each request through the divider
	typedef struct packed {
		logic neg;
		logic fell;
	} side_t;

endpackage

/* hdl/wwa_lane.sv */
`timescale 1ns / 1ps

module wwa_lane #(
	parameter int SAMPLE_BITS = wwa_pkg::SAMPLE_BITS_DEF,
	parameter int WEIGHT_BITS = wwa_pkg::WEIGHT_BITS_DEF,
	parameter int DIST = 0
) (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic signed [SAMPLE_BITS-1:0]            sample,
	input  logic                                     present,
	input  logic [wwa_pkg::HW_BITS-1:0]              limit,
	input  logic [WEIGHT_BITS:0]                     weight,
	output logic signed [SAMPLE_BITS+WEIGHT_BITS+1:0] prod_s1,
	output logic [WEIGHT_BITS:0]                     wgt_s1
);

	localparam int PB = SAMPLE_BITS + WEIGHT_BITS + 2;
	localparam logic [wwa_pkg::HW_BITS-1:0] DIST_CODE = wwa_pkg::HW_BITS'(DIST);

	logic                 used;
	logic [WEIGHT_BITS:0] w_eff;
	logic signed [PB-1:0] prod;

	// Gate the weight: absent frame or outside the window contributes nothing
	assign used = present && (DIST_CODE <= limit);
	assign w_eff = used ? weight : '0;
	assign prod = $signed(sample) * $signed({1'b0, w_eff});

	// Register product and weight used
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			wgt_s1 <= w_eff;
		end
	end

endmodule

/* hdl/wwa_merge.sv */
`timescale 1ns / 1ps

module wwa_merge #(
	parameter int SAMPLE_BITS = wwa_pkg::SAMPLE_BITS_DEF,
	parameter int WEIGHT_BITS = wwa_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic signed [SAMPLE_BITS+WEIGHT_BITS+1:0] prod [wwa_pkg::LANES],
	input  logic [WEIGHT_BITS:0]                      wgt [wwa_pkg::LANES],
	input  logic signed [SAMPLE_BITS-1:0]             center,
	output logic [WEIGHT_BITS+3:0]                    rem_s4,
	output logic [SAMPLE_BITS-1:0]                    low_s4,
	output logic [WEIGHT_BITS+3:0]                    dvs_s4,
	output wwa_pkg::side_t                            side_s4
);

	localparam int PB = SAMPLE_BITS + WEIGHT_BITS + 2;
	localparam int ACC = PB + 3;
	localparam int TW = WEIGHT_BITS + 4;

	logic signed [ACC-1:0] ext [wwa_pkg::LANES];
	logic [TW-1:0]         wext [wwa_pkg::LANES];
	logic signed [ACC-1:0] lo_s2, hi_s2;
	logic [TW-1:0]         wsum_s2;
	logic signed [SAMPLE_BITS-1:0] center_s2;
	logic signed [ACC-1:0] acc_s3;
	logic [TW-1:0]         dvs_s3;
	logic                  fell_s3;
	logic signed [ACC-1:0] acc_sum;
	logic [ACC-1:0]        mag;

	// Sign-extend products, zero-extend weights
	always_comb begin
		for (int k = 0; k < wwa_pkg::LANES; k++) begin
			ext[k] = {{(ACC-PB){prod[k][PB-1]}}, prod[k]};
			wext[k] = TW'(wgt[k]);
		end
	end

	// Stage 2: partial sums of products, total weight
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2 <= ext[0] + ext[1] + ext[2] + ext[3];
			hi_s2 <= ext[4] + ext[5] + ext[6];
			wsum_s2 <= wext[0] + wext[1] + wext[2] + wext[3] + wext[4] + wext[5] + wext[6];
			center_s2 <= center;
		end
	end

	// Stage 3: final sum; on zero weight divide the centre sample by one
	assign acc_sum = lo_s2 + hi_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			if (wsum_s2 == '0) begin
				acc_s3 <= {{(ACC-SAMPLE_BITS){center_s2[SAMPLE_BITS-1]}}, center_s2};
				dvs_s3 <= TW'(1);
				fell_s3 <= 1'b1;
			end else begin
				acc_s3 <= acc_sum;
				dvs_s3 <= wsum_s2;
				fell_s3 <= 1'b0;
			end
		end
	end

	// Stage 4: magnitude and sign, split dividend for the long division
	assign mag = acc_s3[ACC-1] ? (~acc_s3 + 1'b1) : acc_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4 <= mag[SAMPLE_BITS+TW-1:SAMPLE_BITS];
			low_s4 <= mag[SAMPLE_BITS-1:0];
			dvs_s4 <= dvs_s3;
			side_s4.neg <= acc_s3[ACC-1];
			side_s4.fell <= fell_s3;
		end
	end

endmodule

/* hdl/wwa_div_stage.sv */
`timescale 1ns / 1ps

module wwa_div_stage #(
	parameter int SAMPLE_BITS = wwa_pkg::SAMPLE_BITS_DEF,
	parameter int WEIGHT_BITS = wwa_pkg::WEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [WEIGHT_BITS+3:0] rem_i,
	input  logic [SAMPLE_BITS-1:0] low_i,
	input  logic [SAMPLE_BITS-1:0] quo_i,
	input  logic [WEIGHT_BITS+3:0] dvs_i,
	input  wwa_pkg::side_t         side_i,
	output logic [WEIGHT_BITS+3:0] rem_s1,
	output logic [SAMPLE_BITS-1:0] low_s1,
	output logic [SAMPLE_BITS-1:0] quo_s1,
	output logic [WEIGHT_BITS+3:0] dvs_s1,
	output wwa_pkg::side_t         side_s1
);

	localparam int TW = WEIGHT_BITS + 4;

	logic [TW:0] trial;
	logic [TW:0] diff;
	logic        ge;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	assign trial = {rem_i, low_i[SAMPLE_BITS-1]};
	assign diff = trial - {1'b0, dvs_i};
	assign ge = trial >= {1'b0, dvs_i};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? diff[TW-1:0] : trial[TW-1:0];
			low_s1 <= {low_i[SAMPLE_BITS-2:0], 1'b0};
			quo_s1 <= {quo_i[SAMPLE_BITS-2:0], ge};
			dvs_s1 <= dvs_i;
			side_s1 <= side_i;
		end
	end

endmodule

/* hdl/windowed_weighted_average_unit.sv */
`timescale 1ns / 1ps

// Channel   | Signals                                      | Moves
// ----------+----------------------------------------------+---------------------------------
// item      | item_valid, item_ready, sample_*, present_mask | one request: seven samples + mask
// result    | result_valid, result_ready, smoothed, fell_back | one weighted average per request
// config    | psel, penable, pwrite, paddr, pwdata, prdata, pready | half window and four weights
//
// Throughput is one request per cycle while the output buffer has room. A result passes through
// one lane stage, three merge stages and one restoring divider stage per quotient bit before it
// enters the output buffer.
// Reset (arst_n low) empties the pipeline and output buffer and loads the default registers.
// The whole pipeline advances together while the two-entry output buffer has room, so a
// request is still accepted while one finished result waits to be taken.

module windowed_weighted_average_unit #(
	parameter int SAMPLE_BITS = wwa_pkg::SAMPLE_BITS_DEF,
	parameter int WEIGHT_BITS = wwa_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic signed [SAMPLE_BITS-1:0]       sample_m3,
	input  logic signed [SAMPLE_BITS-1:0]       sample_m2,
	input  logic signed [SAMPLE_BITS-1:0]       sample_m1,
	input  logic signed [SAMPLE_BITS-1:0]       sample_center,
	input  logic signed [SAMPLE_BITS-1:0]       sample_p1,
	input  logic signed [SAMPLE_BITS-1:0]       sample_p2,
	input  logic signed [SAMPLE_BITS-1:0]       sample_p3,
	input  logic [wwa_pkg::LANES-1:0]           present_mask,
	// result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [SAMPLE_BITS-1:0]       smoothed,
	output logic                                fell_back,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wwa_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int WB1 = WEIGHT_BITS + 1;
	localparam int PB = SAMPLE_BITS + WEIGHT_BITS + 2;
	localparam int TW = WEIGHT_BITS + 4;
	localparam int QB = SAMPLE_BITS;
	localparam int NST = QB + 4;

	logic [wwa_pkg::HW_BITS-1:0] half_window_q;
	logic [WB1-1:0]              weight_q [wwa_pkg::MAX_HALF_WINDOW+1];
	logic [wwa_pkg::REG_IDX_BITS-1:0] reg_idx;
	logic                        cfg_wr;
	logic [wwa_pkg::HW_BITS-1:0] limit;

	logic                        adv;
	logic [NST-1:0]              valid_q;
	logic signed [SAMPLE_BITS-1:0] samp [wwa_pkg::LANES];
	logic signed [SAMPLE_BITS-1:0] center_s1;
	logic signed [PB-1:0]        prod_s1 [wwa_pkg::LANES];
	logic [WB1-1:0]              wgt_s1 [wwa_pkg::LANES];

	logic [TW-1:0]               rem_w [QB+1];
	logic [QB-1:0]               low_w [QB+1];
	logic [QB-1:0]               quo_w [QB+1];
	logic [TW-1:0]               dvs_w [QB+1];
	wwa_pkg::side_t              side_w [QB+1];

	logic [QB-1:0]               res_val;
	logic                        push, pop;
	logic [SAMPLE_BITS-1:0]      fifo_val_q [2];
	logic                        fifo_fell_q [2];
	logic                        wr_ptr_q, rd_ptr_q;
	logic [1:0]                  count_q;

	// Configuration writes
	assign reg_idx = paddr[wwa_pkg::ADDR_BITS-1:2];
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q <= wwa_pkg::HALF_WINDOW_RST;
			weight_q[0] <= WB1'(wwa_pkg::WEIGHT_CENTER_RST);
			weight_q[1] <= WB1'(wwa_pkg::WEIGHT_DIST1_RST);
			weight_q[2] <= WB1'(wwa_pkg::WEIGHT_DIST2_RST);
			weight_q[3] <= WB1'(wwa_pkg::WEIGHT_DIST3_RST);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				wwa_pkg::REG_HALF_WINDOW: half_window_q <= pwdata[wwa_pkg::HW_BITS-1:0];
				wwa_pkg::REG_WEIGHT_CENTER: weight_q[0] <= pwdata[WB1-1:0];
				wwa_pkg::REG_WEIGHT_DIST1: weight_q[1] <= pwdata[WB1-1:0];
				wwa_pkg::REG_WEIGHT_DIST2: weight_q[2] <= pwdata[WB1-1:0];
				wwa_pkg::REG_WEIGHT_DIST3: weight_q[3] <= pwdata[WB1-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			wwa_pkg::REG_HALF_WINDOW: prdata = 32'(half_window_q);
			wwa_pkg::REG_WEIGHT_CENTER: prdata = 32'(weight_q[0]);
			wwa_pkg::REG_WEIGHT_DIST1: prdata = 32'(weight_q[1]);
			wwa_pkg::REG_WEIGHT_DIST2: prdata = 32'(weight_q[2]);
			wwa_pkg::REG_WEIGHT_DIST3: prdata = 32'(weight_q[3]);
			default: prdata = '0;
		endcase
	end

	// Clamp the half window to MAX_HALF_WINDOW
	assign limit = (32'(half_window_q) > 32'(wwa_pkg::MAX_HALF_WINDOW))
		? wwa_pkg::HW_BITS'(wwa_pkg::MAX_HALF_WINDOW) : half_window_q;

	// Pipeline advances while the output buffer has room
	assign adv = (count_q != 2'd2);
	assign item_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[NST-2:0], item_valid};
		end
	end

	// Lanes: one multiplier per frame
	assign samp[0] = sample_m3;
	assign samp[1] = sample_m2;
	assign samp[2] = sample_m1;
	assign samp[3] = sample_center;
	assign samp[4] = sample_p1;
	assign samp[5] = sample_p2;
	assign samp[6] = sample_p3;

	for (genvar k = 0; k < wwa_pkg::LANES; k++) begin : g_lane
		localparam int D = (k < wwa_pkg::CENTER_LANE) ? (wwa_pkg::CENTER_LANE - k)
			: (k - wwa_pkg::CENTER_LANE);
		wwa_lane #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.WEIGHT_BITS(WEIGHT_BITS),
			.DIST(D)
		) u_lane (
			.clk(clk),
			.en(adv),
			.sample(samp[k]),
			.present(present_mask[k]),
			.limit(limit),
			.weight(weight_q[D]),
			.prod_s1(prod_s1[k]),
			.wgt_s1(wgt_s1[k])
		);
	end

	// Hold the centre sample for the fallback path
	always_ff @(posedge clk) begin
		if (adv) begin
			center_s1 <= sample_center;
		end
	end

	// Merge lanes into dividend and divisor
	wwa_merge #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_merge (
		.clk(clk),
		.en(adv),
		.prod(prod_s1),
		.wgt(wgt_s1),
		.center(center_s1),
		.rem_s4(rem_w[0]),
		.low_s4(low_w[0]),
		.dvs_s4(dvs_w[0]),
		.side_s4(side_w[0])
	);

	assign quo_w[0] = '0;

	// Long division, one quotient bit per stage
	for (genvar g = 0; g < QB; g++) begin : g_div
		wwa_div_stage #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.WEIGHT_BITS(WEIGHT_BITS)
		) u_div (
			.clk(clk),
			.en(adv),
			.rem_i(rem_w[g]),
			.low_i(low_w[g]),
			.quo_i(quo_w[g]),
			.dvs_i(dvs_w[g]),
			.side_i(side_w[g]),
			.rem_s1(rem_w[g+1]),
			.low_s1(low_w[g+1]),
			.quo_s1(quo_w[g+1]),
			.dvs_s1(dvs_w[g+1]),
			.side_s1(side_w[g+1])
		);
	end

	// Restore the sign of the truncated quotient
	assign res_val = side_w[QB].neg ? (~quo_w[QB] + 1'b1) : quo_w[QB];

	// Two-entry output buffer
	assign push = adv && valid_q[NST-1];
	assign pop = result_valid && result_ready;
	assign result_valid = (count_q != 2'd0);
	assign smoothed = fifo_val_q[rd_ptr_q];
	assign fell_back = fifo_fell_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_val_q[wr_ptr_q] <= res_val;
			fifo_fell_q[wr_ptr_q] <= side_w[QB].fell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* dv/windowed_weighted_average_unit_test.sv */
`timescale 1ns / 1ps

module windowed_weighted_average_unit_test;

	localparam int PERIOD = 20;
	localparam int SBITS = wwa_pkg::SAMPLE_BITS_DEF;
	localparam int WBITS = wwa_pkg::WEIGHT_BITS_DEF + 1;
	localparam int SETTLE_CYCLES = SBITS + 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int SIDE_SEND = 0;
	localparam int SIDE_RECV = 1;

	typedef struct packed {
		logic [wwa_pkg::LANES-1:0][SBITS-1:0] lane;
		logic [wwa_pkg::LANES-1:0] mask;
	} frame_t;

	typedef struct packed {
		logic [SBITS-1:0] avg;
		logic fell;
	} mean_t;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic signed [SBITS-1:0] sample_m3, sample_m2, sample_m1, sample_center;
	logic signed [SBITS-1:0] sample_p1, sample_p2, sample_p3;
	logic [wwa_pkg::LANES-1:0] present_mask;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [SBITS-1:0] smoothed;
	logic fell_back;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [wwa_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	frame_t cur_frame = '0;
	frame_t frames_pending [$];
	mean_t means_due [$];

	// Register shadow used by the predictor
	logic [wwa_pkg::HW_BITS-1:0] win_cfg;
	logic [WBITS-1:0] wgt_cfg [wwa_pkg::MAX_HALF_WINDOW+1];

	logic item_took = 1'b0;
	logic result_took = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int calm_run [2];
	int err_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	assign sample_m3 = cur_frame.lane[0];
	assign sample_m2 = cur_frame.lane[1];
	assign sample_m1 = cur_frame.lane[2];
	assign sample_center = cur_frame.lane[3];
	assign sample_p1 = cur_frame.lane[4];
	assign sample_p2 = cur_frame.lane[5];
	assign sample_p3 = cur_frame.lane[6];
	assign present_mask = cur_frame.mask;

	windowed_weighted_average_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	// Weighted mean of present lanes inside the window; centre sample on zero weight
	function automatic mean_t windowed_mean(frame_t f);
		longint acc, wsum, s64, w64;
		int k, span, reach;
		mean_t r;
		acc = 0;
		wsum = 0;
		reach = (int'(win_cfg) > wwa_pkg::MAX_HALF_WINDOW) ? wwa_pkg::MAX_HALF_WINDOW
			: int'(win_cfg);
		for (k = 0; k < wwa_pkg::LANES; k++) begin
			span = (k < wwa_pkg::CENTER_LANE) ? wwa_pkg::CENTER_LANE - k
				: k - wwa_pkg::CENTER_LANE;
			if (f.mask[k] && span <= reach) begin
				s64 = longint'($signed(f.lane[k]));
				w64 = longint'(wgt_cfg[span]);
				acc += s64 * w64;
				wsum += w64;
			end
		end
		if (wsum > 0) begin
			acc = acc / wsum;
			r.avg = acc[SBITS-1:0];
			r.fell = 1'b0;
		end else begin
			r.avg = f.lane[wwa_pkg::CENTER_LANE];
			r.fell = 1'b1;
		end
		return r;
	endfunction

	// Draw a wait count in 0..13, with occasional runs of no waiting
	function automatic int pick_wait(int side);
		if (calm_run[side] > 0) begin
			calm_run[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_run[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'd65536;
			2: return (1 << WBITS) - 1;
			3: return $urandom_range(0, 65536);
			4: return $urandom() & ((1 << WBITS) - 1);
			default: return $urandom_range(1, 30000);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_count++;
		$display("ERROR: result %0d %s: got %h, expected %h", results_seen, what, got, want);
	endtask

	// Append a request to the pending queue
	task automatic add_frame(frame_t f);
		frames_pending.insert(frames_pending.size(), f);
	endtask

	// Drive requests from the pending queue; hold each until taken
	always @(negedge clk) begin
		int gap;
		gap = send_gap;
		if (!(item_valid && !item_took)) begin
			if (gap > 0) begin
				gap--;
				item_valid <= 1'b0;
			end else if (frames_pending.size() > 0) begin
				cur_frame <= frames_pending.pop_front();
				item_valid <= 1'b1;
				gap = pick_wait(SIDE_SEND);
			end else begin
				item_valid <= 1'b0;
			end
		end
		send_gap <= gap;
	end

	// Stall the result side a random number of cycles after each result
	always @(negedge clk) begin
		int gap;
		gap = recv_gap;
		if (result_took)
			gap = pick_wait(SIDE_RECV);
		if (gap > 0) begin
			result_ready <= 1'b0;
			gap--;
		end else begin
			result_ready <= 1'b1;
		end
		recv_gap <= gap;
	end

	// Predict on each accepted request, check each accepted result, watch for hangs
	always @(posedge clk) begin
		mean_t want;
		item_took <= item_valid && item_ready;
		result_took <= result_valid && result_ready;
		if (item_valid && item_ready)
			means_due.insert(means_due.size(), windowed_mean(cur_frame));
		if (result_valid && result_ready) begin
			results_seen++;
			if (means_due.size() == 0) begin
				report_mismatch("unexpected result", smoothed, 0);
			end else begin
				want = means_due.pop_front();
				if (smoothed !== want.avg)
					report_mismatch("smoothed", smoothed, want.avg);
				if (fell_back !== want.fell)
					report_mismatch("fell_back", 32'(fell_back), 32'(want.fell));
			end
		end
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// One APB write; stray upper bits are sometimes set and must be ignored
	task automatic write_reg(logic [wwa_pkg::REG_IDX_BITS-1:0] idx, logic [31:0] value);
		logic [31:0] bus;
		bus = value;
		if ($urandom_range(0, 1))
			bus = bus | ($urandom() & ((idx == wwa_pkg::REG_HALF_WINDOW) ? 32'hFFFF_FFFC
				: 32'hFFFE_0000));
		if (idx == wwa_pkg::REG_HALF_WINDOW)
			win_cfg = bus[wwa_pkg::HW_BITS-1:0];
		else
			wgt_cfg[2'(idx - 3'd1)] = bus[WBITS-1:0];
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= bus;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure_window(logic [31:0] hw, logic [31:0] wc, logic [31:0] w1,
			logic [31:0] w2, logic [31:0] w3);
		write_reg(wwa_pkg::REG_HALF_WINDOW, hw);
		write_reg(wwa_pkg::REG_WEIGHT_CENTER, wc);
		write_reg(wwa_pkg::REG_WEIGHT_DIST1, w1);
		write_reg(wwa_pkg::REG_WEIGHT_DIST2, w2);
		write_reg(wwa_pkg::REG_WEIGHT_DIST3, w3);
	endtask

	// Wait until every request is sent and every result has come back
	task automatic drain();
		@(posedge clk);
		while (frames_pending.size() != 0 || item_valid || means_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_edge_cases();
		frame_t f;
		int k;
		f.mask = 7'h7F;
		f.lane = {wwa_pkg::LANES{32'h7FFF_FFFF}};
		add_frame(f);
		f.lane = {wwa_pkg::LANES{32'h8000_0000}};
		add_frame(f);
		f.lane = '0;
		add_frame(f);
		f.lane = '1;
		add_frame(f);
		f.lane = {wwa_pkg::LANES{32'h0000_0001}};
		add_frame(f);
		f.lane = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
		add_frame(f);
		for (k = 0; k < wwa_pkg::LANES; k++)
			f.lane[k] = $urandom();
		// empty window: centre sample comes back as is
		f.mask = '0;
		f.lane[wwa_pkg::CENTER_LANE] = 32'h8000_0000;
		add_frame(f);
		f.lane[wwa_pkg::CENTER_LANE] = 32'h7FFF_FFFF;
		add_frame(f);
		// only the outermost lanes, then only the centre lane
		f.mask = 7'b1000001;
		add_frame(f);
		f.mask = 7'b0001000;
		add_frame(f);
		// centre absent
		f.mask = 7'b1110111;
		add_frame(f);
		// sequence cut at the start and at the end
		f.mask = 7'b1111000;
		add_frame(f);
		f.mask = 7'b0001111;
		add_frame(f);
		// negative quotient truncates toward zero
		f.mask = 7'b0011100;
		f.lane = '0;
		f.lane[wwa_pkg::CENTER_LANE] = 32'hFFFF_FFFD;
		add_frame(f);
	endtask

	task automatic queue_random(int n);
		frame_t f;
		logic [31:0] base;
		int i, k;
		for (i = 0; i < n; i++) begin
			base = $urandom();
			if ($urandom_range(0, 3) != 0)
				base = {{12{base[19]}}, base[19:0]};
			for (k = 0; k < wwa_pkg::LANES; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: f.lane[k] = $urandom();
					9: begin
						case ($urandom_range(0, 3))
							0: f.lane[k] = 32'h7FFF_FFFF;
							1: f.lane[k] = 32'h8000_0000;
							2: f.lane[k] = '0;
							default: f.lane[k] = '1;
						endcase
					end
					default: f.lane[k] = base + $urandom_range(0, 8191) - 4096;
				endcase
			end
			if ($urandom_range(0, 49) == 0)
				f.lane = $urandom_range(0, 1) ? {wwa_pkg::LANES{32'h7FFF_FFFF}}
					: {wwa_pkg::LANES{32'h8000_0000}};
			case ($urandom_range(0, 7))
				0, 1, 2: f.mask = wwa_pkg::LANES'($urandom_range(0, 127));
				3, 4: f.mask = 7'h7F;
				5: f.mask = 7'h7F << $urandom_range(1, 3);
				6: f.mask = 7'h7F >> $urandom_range(1, 3);
				default: f.mask = 7'b1 << $urandom_range(0, wwa_pkg::LANES - 1);
			endcase
			add_frame(f);
		end
	endtask

	initial begin
		int p;
		win_cfg = wwa_pkg::HALF_WINDOW_RST;
		wgt_cfg[0] = WBITS'(wwa_pkg::WEIGHT_CENTER_RST);
		wgt_cfg[1] = WBITS'(wwa_pkg::WEIGHT_DIST1_RST);
		wgt_cfg[2] = WBITS'(wwa_pkg::WEIGHT_DIST2_RST);
		wgt_cfg[3] = WBITS'(wwa_pkg::WEIGHT_DIST3_RST);
		calm_run[SIDE_SEND] = 0;
		calm_run[SIDE_RECV] = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings first
		queue_edge_cases();
		queue_random(ITEMS_PER_PHASE / 2);
		drain();

		// Extreme settings: full range, above one, all zero, single lane
		configure_window(3, 65536, 65536, 65536, 65536);
		queue_edge_cases();
		queue_random(ITEMS_PER_PHASE);
		drain();
		configure_window(0, (1 << WBITS) - 1, 0, 0, 0);
		queue_random(ITEMS_PER_PHASE);
		drain();
		configure_window(3, 0, 0, 0, 0);
		queue_random(ITEMS_PER_PHASE / 2);
		drain();
		configure_window(1, 0, (1 << WBITS) - 1, 1, (1 << WBITS) - 1);
		queue_random(ITEMS_PER_PHASE);
		drain();
		configure_window(3, 1, 1, 1, 1);
		queue_random(ITEMS_PER_PHASE);
		drain();
		configure_window(3, (1 << WBITS) - 1, (1 << WBITS) - 1, (1 << WBITS) - 1,
			(1 << WBITS) - 1);
		queue_edge_cases();
		queue_random(ITEMS_PER_PHASE);
		drain();
		configure_window(2, 0, 0, 0, 65536);
		queue_random(ITEMS_PER_PHASE / 2);
		drain();

		// Random settings
		for (p = 0; p < 6; p++) begin
			configure_window($urandom_range(0, 3), pick_weight(), pick_weight(),
				pick_weight(), pick_weight());
			queue_random(ITEMS_PER_PHASE);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (means_due.size() != 0)
			report_mismatch("results missing", means_due.size(), 0);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
